/* src/burst_gate_controller_core_assert.svh */
// Assertion macros shared by the burst gate controller RTL.
`ifndef BURST_GATE_CONTROLLER_CORE_ASSERT_SVH
`define BURST_GATE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bgc_pkg.sv */
// Types and constants of the burst gate controller.
package bgc_pkg;

    localparam int TICK_W    = 32;
    localparam int DELAY_W   = 20;
    localparam int DLIM_W    = DELAY_W + 1;
    localparam int CONTENT_W = 24;
    localparam int PLAY_W    = 18;
    // Sample count of content plus half margin; half margin stays below 2**CONTENT_W
    localparam int SAMP_W    = CONTENT_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [PLAY_W-1:0] PLAY_LIMIT_MAX = 18'h3FFFF;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_PROCESS = 3'd1,
        CMD_TRIGGER = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_ABORT   = 3'd4,
        CMD_SYNC    = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_ON_CH0 = 3'd0,
        CFG_BURST_ON_CH1 = 3'd1,
        CFG_ENDLESS_CH0  = 3'd2,
        CFG_ENDLESS_CH1  = 3'd3,
        CFG_DELAY_US_CH0 = 3'd4,
        CFG_DELAY_US_CH1 = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_PLAY  = 2'd2
    } t_phase;

    // Decoded per-channel operation, at most one bit set
    typedef struct packed {
        logic tick;
        logic process;
        logic trigger;
        logic stop;
        logic abort;
        logic sync;
    } t_chan_op;

    typedef struct packed {
        logic   enable;
        logic   running;
        t_phase phase;
    } t_chan_status;

endpackage

/* src/bgc_chan.sv */
// One burst gate channel: phase, tick counter, limits and enable bit.
`include "burst_gate_controller_core_assert.svh"
module bgc_chan #(
    parameter int MARGIN_SAMPLES   = 1024,
    parameter int SAMPLES_PER_TICK = 100
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bgc_pkg::t_chan_op               i_op,
    input  logic [bgc_pkg::CONTENT_W-1:0]   i_content_len,
    input  logic                            i_burst_on,
    input  logic                            i_endless,
    input  logic [bgc_pkg::DELAY_W-1:0]     i_delay_us,
    output bgc_pkg::t_chan_status           o_status
);
    import bgc_pkg::*;

    // Scaled tick count: tick * SAMPLES_PER_TICK, held while tick < PLAY_LIMIT_MAX
    localparam int ACC_W       = PLAY_W + $clog2(SAMPLES_PER_TICK + 1);
    localparam int CMP_W       = (ACC_W > SAMP_W) ? ACC_W : SAMP_W;
    localparam int HALF_MARGIN = MARGIN_SAMPLES / 2;

    t_phase              r_phase,   n_phase;
    logic [TICK_W-1:0]   r_tick,    n_tick;
    logic [ACC_W-1:0]    r_acc,     n_acc;
    logic [DLIM_W-1:0]   r_dlim,    n_dlim;
    logic [SAMP_W-1:0]   r_samples, n_samples;
    logic                r_running, n_running;
    logic                r_enable,  n_enable;

    logic delay_done;
    logic play_done;

    // Play ends when ceil(samples / SPT) <= tick, i.e. tick * SPT >= samples,
    // or when the tick count reaches the saturated play limit.
    assign delay_done = (r_tick >= TICK_W'(r_dlim));
    assign play_done  = (r_tick >= TICK_W'(PLAY_LIMIT_MAX)) ||
                        (CMP_W'(r_acc) >= CMP_W'(r_samples));

    // Next state for the decoded operation
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_acc     = r_acc;
        n_dlim    = r_dlim;
        n_samples = r_samples;
        n_running = r_running;
        n_enable  = r_enable;

        if (i_op.tick) begin
            if (r_phase != PH_IDLE && r_tick != '1) begin
                n_tick = r_tick + TICK_W'(1);
                if (r_tick < TICK_W'(PLAY_LIMIT_MAX)) begin
                    n_acc = r_acc + ACC_W'(SAMPLES_PER_TICK);
                end
            end
        end else if (i_op.process) begin
            unique case (r_phase)
                PH_DELAY: begin
                    if (delay_done) begin
                        n_tick   = '0;
                        n_acc    = '0;
                        n_phase  = PH_PLAY;
                        n_enable = 1'b1;
                    end
                end
                PH_PLAY: begin
                    if (play_done) begin
                        n_enable  = 1'b0;
                        n_phase   = PH_IDLE;
                        n_running = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_op.trigger) begin
            if (i_burst_on) begin
                if (i_endless) begin
                    // Endless mode toggles continuous output
                    if (r_enable) begin
                        n_enable  = 1'b0;
                        n_running = 1'b0;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_enable  = 1'b1;
                        n_running = 1'b1;
                    end
                end else if (r_phase == PH_IDLE) begin
                    n_tick    = '0;
                    n_acc     = '0;
                    n_dlim    = {i_delay_us, 1'b0};
                    n_samples = SAMP_W'(i_content_len) + SAMP_W'(HALF_MARGIN);
                    n_phase   = PH_DELAY;
                    n_running = 1'b1;
                end
            end
        end else if (i_op.stop) begin
            n_phase   = PH_IDLE;
            n_running = 1'b0;
            n_enable  = 1'b0;
        end else if (i_op.abort) begin
            n_phase   = PH_IDLE;
            n_running = 1'b0;
        end else if (i_op.sync) begin
            n_enable = 1'b1;
        end
    end

    // Channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_acc     <= '0;
            r_dlim    <= '0;
            r_samples <= '0;
            r_running <= 1'b0;
            r_enable  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_acc     <= n_acc;
            r_dlim    <= n_dlim;
            r_samples <= n_samples;
            r_running <= n_running;
            r_enable  <= n_enable;
        end
    end

    assign o_status.enable  = r_enable;
    assign o_status.running = r_running;
    assign o_status.phase   = r_phase;

    `BGC_ASSERT_NOW(a_acc_tracks_tick, i_clk, i_rst_n,
        r_tick < TICK_W'(PLAY_LIMIT_MAX),
        (CMP_W'(r_tick[PLAY_W-1:0]) * CMP_W'(SAMPLES_PER_TICK)) == CMP_W'(r_acc),
        "scaled tick count out of step with tick count")
    `BGC_ASSERT_NEXT(a_delay_to_play, i_clk, i_rst_n,
        i_op.process && r_phase == PH_DELAY && delay_done,
        r_phase == PH_PLAY && r_enable && r_tick == '0,
        "delay expiry did not start playing")
    `BGC_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n,
        i_op.stop,
        r_phase == PH_IDLE && !r_running && !r_enable,
        "stop left channel active")
    `BGC_ASSERT_NEXT(a_hold_without_op, i_clk, i_rst_n,
        i_op == '0,
        $stable(r_phase) && $stable(r_tick) && $stable(r_enable) && $stable(r_running),
        "channel state changed without an operation")

endmodule

/* src/burst_gate_controller_core.sv */
// Top level of the two-channel burst gate controller.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command beat: i_cmd,
//   i_channel, i_content_len. Every command beat produces exactly one result
//   beat on the output channel (o_out_valid / i_out_ready) carrying both
//   channels' enable bits, running flags and phases after the command.
//   Configuration beats (i_cfg_valid / o_cfg_ready) write register
//   i_cfg_index with i_cfg_data; unknown indexes are dropped. Write them only
//   while no command beat is in flight.
// Timing:
//   An input beat passes through an input register, then the state update,
//   whose registers also hold the result.
//   Throughput is one beat per cycle while the receiver keeps i_out_ready high;
//   the play-end check compares a running tick*SAMPLES_PER_TICK product against
//   the sample count, so no divider sits in the path.
// Reset: synchronous, active low; all channels idle, outputs disabled,
//   configuration cleared, no result pending.
// Stall: while the receiver holds i_out_ready low the pending result and
//   channel state hold; one more input beat is buffered, then o_in_ready drops.
`include "burst_gate_controller_core_assert.svh"
module burst_gate_controller_core #(
    parameter int MARGIN_SAMPLES   = 1024,
    parameter int SAMPLES_PER_TICK = 100
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_cmd,
    input  logic                            i_channel,
    input  logic [bgc_pkg::CONTENT_W-1:0]   i_content_len,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_out_en_ch0,
    output logic                            o_out_en_ch1,
    output logic                            o_running_ch0,
    output logic                            o_running_ch1,
    output logic [1:0]                      o_phase_ch0,
    output logic [1:0]                      o_phase_ch1,
    // Configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bgc_pkg::DELAY_W-1:0]     i_cfg_data
);
    import bgc_pkg::*;

    logic                  r_in_valid;
    t_cmd                  r_cmd;
    logic                  r_channel;
    logic [CONTENT_W-1:0]  r_content;
    logic                  r_out_valid;

    logic                  r_burst_on_ch0, r_burst_on_ch1;
    logic                  r_endless_ch0,  r_endless_ch1;
    logic [DELAY_W-1:0]    r_delay_us_ch0, r_delay_us_ch1;

    logic                  exec;
    logic                  in_accept;
    t_chan_op              op_ch0, op_ch1;
    t_chan_status          st_ch0, st_ch1;

    // Handshake: execute when the result slot is free or being drained
    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_channel <= i_channel;
            r_content <= i_content_len;
        end
    end

    // Result valid; payload lives in the channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_on_ch0 <= 1'b0;
            r_burst_on_ch1 <= 1'b0;
            r_endless_ch0  <= 1'b0;
            r_endless_ch1  <= 1'b0;
            r_delay_us_ch0 <= '0;
            r_delay_us_ch1 <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BURST_ON_CH0: r_burst_on_ch0 <= i_cfg_data[0];
                CFG_BURST_ON_CH1: r_burst_on_ch1 <= i_cfg_data[0];
                CFG_ENDLESS_CH0:  r_endless_ch0  <= i_cfg_data[0];
                CFG_ENDLESS_CH1:  r_endless_ch1  <= i_cfg_data[0];
                CFG_DELAY_US_CH0: r_delay_us_ch0 <= i_cfg_data;
                CFG_DELAY_US_CH1: r_delay_us_ch1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Command decode to per-channel operations
    always_comb begin
        op_ch0 = '0;
        op_ch1 = '0;
        if (exec) begin
            unique case (r_cmd)
                CMD_TICK: begin
                    op_ch0.tick = !r_channel;
                    op_ch1.tick = r_channel;
                end
                CMD_PROCESS: begin
                    op_ch0.process = 1'b1;
                    op_ch1.process = 1'b1;
                end
                CMD_TRIGGER: begin
                    op_ch0.trigger = !r_channel;
                    op_ch1.trigger = r_channel;
                end
                CMD_STOP: begin
                    op_ch0.stop = !r_channel;
                    op_ch1.stop = r_channel;
                end
                CMD_ABORT: begin
                    op_ch0.abort = !r_channel;
                    op_ch1.abort = r_channel;
                end
                CMD_SYNC: begin
                    op_ch0.sync = 1'b1;
                    op_ch1.sync = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    bgc_chan #(
        .MARGIN_SAMPLES   (MARGIN_SAMPLES),
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
    ) u_chan0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op_ch0),
        .i_content_len (r_content),
        .i_burst_on    (r_burst_on_ch0),
        .i_endless     (r_endless_ch0),
        .i_delay_us    (r_delay_us_ch0),
        .o_status      (st_ch0)
    );

    bgc_chan #(
        .MARGIN_SAMPLES   (MARGIN_SAMPLES),
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
    ) u_chan1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op_ch1),
        .i_content_len (r_content),
        .i_burst_on    (r_burst_on_ch1),
        .i_endless     (r_endless_ch1),
        .i_delay_us    (r_delay_us_ch1),
        .o_status      (st_ch1)
    );

    // Result beat
    assign o_out_valid   = r_out_valid;
    assign o_out_en_ch0  = st_ch0.enable;
    assign o_out_en_ch1  = st_ch1.enable;
    assign o_running_ch0 = st_ch0.running;
    assign o_running_ch1 = st_ch1.running;
    assign o_phase_ch0   = st_ch0.phase;
    assign o_phase_ch1   = st_ch1.phase;

    `BGC_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n,
        in_accept,
        r_in_valid,
        "accepted beat not held in input register")
    `BGC_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n,
        exec,
        r_out_valid,
        "executed beat produced no result")
    `BGC_ASSERT_NEXT(a_stall_holds_item, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_out_ready,
        r_in_valid && $stable(r_cmd) && $stable(r_channel) && $stable(r_content),
        "buffered beat lost during output stall")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel burst gate controller core.
module testbench;
    import bgc_pkg::*;

    localparam int MARGIN_SAMPLES   = 1024;
    localparam int SAMPLES_PER_TICK = 100;
    localparam int CLK_PERIOD       = 4;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASE_ITEMS      = 165;

    // Command codes the block decodes as no-ops
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic CH0 = 1'b0;
    localparam logic CH1 = 1'b1;

    typedef struct packed {
        logic [2:0]           cmd;
        logic                 chan;
        logic [CONTENT_W-1:0] content;
    } t_gate_cmd;

    typedef struct packed {
        logic       en0;
        logic       en1;
        logic       run0;
        logic       run1;
        logic [1:0] ph0;
        logic [1:0] ph1;
    } t_gate_status;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [2:0]           i_cmd;
    logic                 i_channel;
    logic [CONTENT_W-1:0] i_content_len;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_out_en_ch0;
    logic                 o_out_en_ch1;
    logic                 o_running_ch0;
    logic                 o_running_ch1;
    logic [1:0]           o_phase_ch0;
    logic [1:0]           o_phase_ch1;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DELAY_W-1:0]   i_cfg_data;

    // Stimulus and scoreboard
    t_gate_cmd    pending_cmds[$];
    t_gate_status gate_expect[$];
    t_gate_cmd    next_cmd;
    t_gate_status seen_status;
    t_gate_status want_status;
    logic         cmd_beat_taken;
    int           pushed_items;
    int           gate_errors;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           holdoff_req;
    int           hold_left;

    // Shadow configuration and per-channel timer state
    logic               cfg_burst_on [2];
    logic               cfg_endless [2];
    logic [DELAY_W-1:0] cfg_delay_us [2];
    t_phase             ch_phase [2];
    logic [TICK_W-1:0]  ch_ticks [2];
    logic [DLIM_W-1:0]  ch_delay_lim [2];
    logic [PLAY_W-1:0]  ch_play_lim [2];
    logic               ch_running [2];
    logic               ch_enable [2];

    burst_gate_controller_core #(
        .MARGIN_SAMPLES   (MARGIN_SAMPLES),
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_channel     (i_channel),
        .i_content_len (i_content_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_en_ch0  (o_out_en_ch0),
        .o_out_en_ch1  (o_out_en_ch1),
        .o_running_ch0 (o_running_ch0),
        .o_running_ch1 (o_running_ch1),
        .o_phase_ch0   (o_phase_ch0),
        .o_phase_ch1   (o_phase_ch1),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Play length in ticks: content plus half margin, rounded up, clamped to 18 bits
    function automatic logic [PLAY_W-1:0] play_len_ticks(input logic [CONTENT_W-1:0] len);
        longint q;
        q = (longint'(len) + MARGIN_SAMPLES / 2 + SAMPLES_PER_TICK - 1) / SAMPLES_PER_TICK;
        if (q > longint'(PLAY_LIMIT_MAX)) begin
            q = longint'(PLAY_LIMIT_MAX);
        end
        return q[PLAY_W-1:0];
    endfunction

    // Advance the timer state by one command and return both channels' status
    function automatic t_gate_status apply_gate_cmd(input t_gate_cmd item);
        int c;
        int k;
        c = item.chan;
        case (item.cmd)
            CMD_TICK: begin
                if (ch_phase[c] != PH_IDLE && ch_ticks[c] != '1) begin
                    ch_ticks[c] = ch_ticks[c] + 1'b1;
                end
            end
            CMD_PROCESS: begin
                for (k = 0; k < 2; k++) begin
                    if (ch_phase[k] == PH_DELAY) begin
                        if (ch_ticks[k] >= ch_delay_lim[k]) begin
                            ch_ticks[k]  = '0;
                            ch_phase[k]  = PH_PLAY;
                            ch_enable[k] = 1'b1;
                        end
                    end else if (ch_phase[k] == PH_PLAY) begin
                        if (ch_ticks[k] >= ch_play_lim[k]) begin
                            ch_enable[k]  = 1'b0;
                            ch_phase[k]   = PH_IDLE;
                            ch_running[k] = 1'b0;
                        end
                    end
                end
            end
            CMD_TRIGGER: begin
                if (cfg_burst_on[c]) begin
                    if (cfg_endless[c]) begin
                        // endless mode toggles the output, phase left alone on turn-off
                        if (ch_enable[c]) begin
                            ch_enable[c]  = 1'b0;
                            ch_running[c] = 1'b0;
                        end else begin
                            ch_phase[c]   = PH_IDLE;
                            ch_enable[c]  = 1'b1;
                            ch_running[c] = 1'b1;
                        end
                    end else if (ch_phase[c] == PH_IDLE) begin
                        ch_ticks[c]     = '0;
                        ch_delay_lim[c] = {cfg_delay_us[c], 1'b0};
                        ch_play_lim[c]  = play_len_ticks(item.content);
                        ch_phase[c]     = PH_DELAY;
                        ch_running[c]   = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                ch_phase[c]   = PH_IDLE;
                ch_running[c] = 1'b0;
                ch_enable[c]  = 1'b0;
            end
            CMD_ABORT: begin
                ch_phase[c]   = PH_IDLE;
                ch_running[c] = 1'b0;
            end
            CMD_SYNC: begin
                ch_enable[0] = 1'b1;
                ch_enable[1] = 1'b1;
            end
            default: begin
            end
        endcase
        return '{en0: ch_enable[0], en1: ch_enable[1], run0: ch_running[0],
                 run1: ch_running[1], ph0: ch_phase[0], ph1: ch_phase[1]};
    endfunction

    // Command driver: new beat at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || cmd_beat_taken)) begin
            cmd_beat_taken = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                i_in_valid    <= 1'b1;
                i_cmd         <= next_cmd.cmd;
                i_channel     <= next_cmd.chan;
                i_content_len <= next_cmd.content;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (holdoff_req != 0) begin
            hold_left   = holdoff_req;
            holdoff_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check result beats, then predict for the command beat taken this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_status = '{en0: o_out_en_ch0, en1: o_out_en_ch1,
                                run0: o_running_ch0, run1: o_running_ch1,
                                ph0: o_phase_ch0, ph1: o_phase_ch1};
                if (gate_expect.size() == 0) begin
                    gate_errors++;
                    if (gate_errors <= MAX_REPORTS) begin
                        $display({"cycle %0d: result beat with none expected: ",
                                  "en=%b%b run=%b%b ph=%0d/%0d"},
                                 cycle_count, seen_status.en0, seen_status.en1,
                                 seen_status.run0, seen_status.run1,
                                 seen_status.ph0, seen_status.ph1);
                    end
                end else begin
                    want_status = gate_expect.pop_front();
                    if (seen_status !== want_status) begin
                        gate_errors++;
                        if (gate_errors <= MAX_REPORTS) begin
                            $display({"cycle %0d: expected en=%b%b run=%b%b ph=%0d/%0d, ",
                                      "got en=%b%b run=%b%b ph=%0d/%0d"},
                                     cycle_count, want_status.en0, want_status.en1,
                                     want_status.run0, want_status.run1, want_status.ph0,
                                     want_status.ph1, seen_status.en0, seen_status.en1,
                                     seen_status.run0, seen_status.run1, seen_status.ph0,
                                     seen_status.ph1);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                gate_expect.push_back(apply_gate_cmd('{cmd: i_cmd, chan: i_channel,
                                                       content: i_content_len}));
                cmd_beat_taken = 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("burst_gate_controller_core test failed");
            $finish;
        end
    end

    task automatic push_item(input logic [2:0] cmd, input logic chan,
                             input logic [CONTENT_W-1:0] content);
        pending_cmds.push_back('{cmd: cmd, chan: chan, content: content});
        pushed_items++;
    endtask

    // Any command code, either channel, mostly short content
    task automatic push_noise();
        logic [CONTENT_W-1:0] len;
        if ($urandom_range(0, 3) == 0) begin
            len = CONTENT_W'($urandom());
        end else begin
            len = CONTENT_W'($urandom_range(0, 1500));
        end
        push_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), len);
    endtask

    // Trigger one channel, then mostly ticks and expiry checks on it
    task automatic push_burst();
        logic                 c;
        int                   steps;
        int                   r;
        logic [CONTENT_W-1:0] len;
        c = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 39) == 0) begin
            len = CONTENT_W'($urandom());
        end else begin
            len = CONTENT_W'($urandom_range(0, 1200));
        end
        push_item(CMD_TRIGGER, c, len);
        steps = $urandom_range(8, 40);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_item(CMD_TICK, c, CONTENT_W'($urandom_range(0, 1500)));
            end else if (r < 85) begin
                push_item(CMD_PROCESS, 1'($urandom_range(0, 1)), CONTENT_W'($urandom()));
            end else if (r < 93) begin
                push_item(CMD_TICK, ~c, CONTENT_W'($urandom_range(0, 1500)));
            end else begin
                push_noise();
            end
        end
    endtask

    task automatic fill_random(input int n);
        int target;
        target = pushed_items + n;
        while (pushed_items < target) begin
            if ($urandom_range(0, 99) < 70) begin
                push_burst();
            end else begin
                repeat ($urandom_range(1, 4)) push_noise();
            end
        end
    endtask

    // Block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_gate_idle();
        while (pending_cmds.size() != 0 || i_in_valid || gate_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DELAY_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BURST_ON_CH0: cfg_burst_on[0] = data[0];
            CFG_BURST_ON_CH1: cfg_burst_on[1] = data[0];
            CFG_ENDLESS_CH0:  cfg_endless[0]  = data[0];
            CFG_ENDLESS_CH1:  cfg_endless[1]  = data[0];
            CFG_DELAY_US_CH0: cfg_delay_us[0] = data;
            CFG_DELAY_US_CH1: cfg_delay_us[1] = data;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic b0, input logic b1, input logic e0, input logic e1,
                              input logic [DELAY_W-1:0] d0, input logic [DELAY_W-1:0] d1);
        write_reg(CFG_BURST_ON_CH0, DELAY_W'(b0));
        write_reg(CFG_BURST_ON_CH1, DELAY_W'(b1));
        write_reg(CFG_ENDLESS_CH0, DELAY_W'(e0));
        write_reg(CFG_ENDLESS_CH1, DELAY_W'(e1));
        write_reg(CFG_DELAY_US_CH0, d0);
        write_reg(CFG_DELAY_US_CH1, d1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic b0, input logic b1, input logic e0, input logic e1,
                                input logic [DELAY_W-1:0] d0, input logic [DELAY_W-1:0] d1,
                                input int sidle, input int rstall, input int hold);
        wait_gate_idle();
        set_config(b0, b1, e0, e1, d0, d1);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        holdoff_req    = hold;
        fill_random(PHASE_ITEMS);
    endtask

    initial begin
        int k;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = '0;
        i_channel      = 1'b0;
        i_content_len  = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        cmd_beat_taken = 1'b0;
        pushed_items   = 0;
        gate_errors    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 0;
        hold_left      = 0;
        for (k = 0; k < 2; k++) begin
            cfg_burst_on[k] = 1'b0;
            cfg_endless[k]  = 1'b0;
            cfg_delay_us[k] = '0;
            ch_phase[k]     = PH_IDLE;
            ch_ticks[k]     = '0;
            ch_delay_lim[k] = '0;
            ch_play_lim[k]  = '0;
            ch_running[k]   = 1'b0;
            ch_enable[k]    = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Burst switches still off after reset: triggers ignored
        push_item(CMD_TRIGGER, CH0, '0);
        push_item(CMD_TRIGGER, CH1, '1);
        push_item(CMD_SYNC, CH1, '0);
        push_item(CMD_STOP, CH0, '0);
        wait_gate_idle();

        // Directed finite bursts: zero delay on channel 0, one microsecond on channel 1
        set_config(1'b1, 1'b1, 1'b0, 1'b0, 20'd0, 20'd1);
        push_item(CMD_RSVD_6, CH1, '1);
        push_item(CMD_TRIGGER, CH0, '0);
        push_item(CMD_PROCESS, CH1, '0);
        repeat (6) push_item(CMD_TICK, CH0, '0);
        push_item(CMD_PROCESS, CH0, '0);
        push_item(CMD_TRIGGER, CH1, '1);
        push_item(CMD_PROCESS, CH1, '0);
        repeat (2) push_item(CMD_TICK, CH1, '0);
        push_item(CMD_PROCESS, CH1, '1);
        // retrigger while playing is ignored
        push_item(CMD_TRIGGER, CH1, '0);
        push_item(CMD_SYNC, CH0, '0);
        push_item(CMD_ABORT, CH1, '0);
        push_item(CMD_STOP, CH1, '0);
        push_item(CMD_TICK, CH0, '0);
        push_item(CMD_TRIGGER, CH0, 24'd1);
        push_item(CMD_ABORT, CH0, '0);
        push_item(CMD_RSVD_7, CH0, '0);
        push_item(CMD_STOP, CH0, '1);

        // Random phases over settings and idling patterns
        random_phase(1'b1, 1'b1, 1'b0, 1'b0, 20'd0, 20'd1, 0, 0, 0);
        random_phase(1'b1, 1'b1, 1'b1, 1'b1, 20'd2, 20'd3, 74, 0, 0);
        random_phase(1'b1, 1'b0, 1'b0, 1'b1, 20'hFFFFF, 20'd0, 0, 74, 0);
        random_phase(1'b0, 1'b1, 1'b1, 1'b0, 20'd3, 20'hFFFFF, 12, 12, 0);
        // receiver holds off while the sender keeps offering: backpressure
        random_phase(1'b1, 1'b1, 1'b0, 1'b1, 20'd1, 20'd2, 0, 0, 300);
        random_phase(1'b1, 1'b1, 1'b1, 1'b0, 20'd0, 20'd0, 74, 0, 0);
        random_phase(1'b1, 1'b1, 1'b0, 1'b0, 20'd2, 20'd0, 0, 74, 0);
        random_phase(1'b1, 1'b1, 1'b0, 1'b0, 20'd1, 20'd3, 12, 12, 0);

        wait_gate_idle();
        if (gate_errors == 0 && gate_expect.size() == 0) begin
            $display("burst_gate_controller_core test passed");
        end else begin
            $display("burst_gate_controller_core test failed");
        end
        $finish;
    end

endmodule
